### design/psd_pkg.sv
`default_nettype none
package psd_pkg;

	localparam int CW     = 32;          // coordinate width
	localparam int PF     = 16;          // fraction bits of the segment parameter
	localparam int VW     = CW + 1;      // coordinate difference
	localparam int PW     = 2 * VW;      // product of two differences
	localparam int LW     = PW + 1;      // squared length
	localparam int DW     = PW + 2;      // signed dot product
	localparam int SQ_W   = PW + 2;      // sum of squared distances (even)
	localparam int RT_W   = SQ_W / 2;    // square root width
	localparam int REM_W  = RT_W + 2;    // square root remainder
	localparam int DIST_W = CW + 1;
	localparam int POS_W  = PF + 1;
	localparam int STP_W  = VW + POS_W;
	localparam int LAT    = 9 + PF + RT_W;

	localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << PF;

	typedef logic [2:0][CW-1:0] pt_t;
	typedef logic [2:0][VW-1:0] vmag_t;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_END   = 2'd1,
		MODE_INNER = 2'd2
	} mode_t;

	typedef struct packed {
		pt_t        p;
		pt_t        e;
		pt_t        q;
		vmag_t      vmag;
		logic [2:0] vneg;
		mode_t      mode;
	} div_side_t;

	typedef struct packed {
		pt_t              near;
		logic [POS_W-1:0] pos;
	} sq_side_t;

endpackage
`default_nettype wire

### design/psd_div.sv
`default_nettype none
module psd_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [psd_pkg::LW-1:0]  in_len,
	input  logic [psd_pkg::LW-1:0]  in_rem,
	input  psd_pkg::div_side_t      in_side,
	output logic                    out_valid,
	output logic [psd_pkg::PF-1:0]  out_quot,
	output psd_pkg::div_side_t      out_side
);
	import psd_pkg::*;

	// one quotient bit per stage, restoring
	logic            vld_s  [PF];
	logic [LW-1:0]   len_s  [PF];
	logic [LW-1:0]   rem_s  [PF];
	logic [PF-1:0]   quo_s  [PF];
	div_side_t       side_s [PF];

	genvar k;
	generate
		for (k = 0; k < PF; k++) begin : g_stage
			logic            cur_vld;
			logic [LW-1:0]   cur_len;
			logic [LW-1:0]   cur_rem;
			logic [PF-1:0]   cur_quo;
			div_side_t       cur_side;
			logic [LW:0]     shl;
			logic [LW:0]     dif;

			if (k == 0) begin : g_first
				assign cur_vld  = in_valid;
				assign cur_len  = in_len;
				assign cur_rem  = in_rem;
				assign cur_quo  = '0;
				assign cur_side = in_side;
			end else begin : g_next
				assign cur_vld  = vld_s[k-1];
				assign cur_len  = len_s[k-1];
				assign cur_rem  = rem_s[k-1];
				assign cur_quo  = quo_s[k-1];
				assign cur_side = side_s[k-1];
			end

			assign shl = {cur_rem, 1'b0};
			assign dif = shl - {1'b0, cur_len};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else begin
					vld_s[k] <= cur_vld;
				end
			end

			always_ff @(posedge clk) begin
				len_s[k]  <= cur_len;
				side_s[k] <= cur_side;
				quo_s[k]  <= {cur_quo[PF-2:0], ~dif[LW]};
				if (!dif[LW]) begin
					rem_s[k] <= dif[LW-1:0];
				end else begin
					rem_s[k] <= shl[LW-1:0];
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[PF-1];
	assign out_quot  = quo_s[PF-1];
	assign out_side  = side_s[PF-1];

endmodule
`default_nettype wire

### design/psd_sqrt.sv
`default_nettype none
module psd_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [psd_pkg::SQ_W-1:0]  in_val,
	input  psd_pkg::sq_side_t         in_side,
	output logic                      out_valid,
	output logic [psd_pkg::RT_W-1:0]  out_root,
	output psd_pkg::sq_side_t         out_side
);
	import psd_pkg::*;

	// one root bit per stage, two radicand bits consumed each time
	logic             vld_s  [RT_W];
	logic [SQ_W-1:0]  rad_s  [RT_W];
	logic [REM_W-1:0] rem_s  [RT_W];
	logic [RT_W-1:0]  root_s [RT_W];
	sq_side_t         side_s [RT_W];

	genvar k;
	generate
		for (k = 0; k < RT_W; k++) begin : g_stage
			logic             cur_vld;
			logic [SQ_W-1:0]  cur_rad;
			logic [REM_W-1:0] cur_rem;
			logic [RT_W-1:0]  cur_root;
			sq_side_t         cur_side;
			logic [REM_W-1:0] remc;
			logic [REM_W-1:0] trial;
			logic [REM_W:0]   dif;

			if (k == 0) begin : g_first
				assign cur_vld  = in_valid;
				assign cur_rad  = in_val;
				assign cur_rem  = '0;
				assign cur_root = '0;
				assign cur_side = in_side;
			end else begin : g_next
				assign cur_vld  = vld_s[k-1];
				assign cur_rad  = rad_s[k-1];
				assign cur_rem  = rem_s[k-1];
				assign cur_root = root_s[k-1];
				assign cur_side = side_s[k-1];
			end

			assign remc  = {cur_rem[REM_W-3:0], cur_rad[SQ_W-1 -: 2]};
			assign trial = {cur_root, 2'b01};
			assign dif   = {1'b0, remc} - {1'b0, trial};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else begin
					vld_s[k] <= cur_vld;
				end
			end

			always_ff @(posedge clk) begin
				rad_s[k]  <= {cur_rad[SQ_W-3:0], 2'b00};
				side_s[k] <= cur_side;
				root_s[k] <= {cur_root[RT_W-2:0], ~dif[REM_W]};
				if (!dif[REM_W]) begin
					rem_s[k] <= dif[REM_W-1:0];
				end else begin
					rem_s[k] <= remc;
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[RT_W-1];
	assign out_root  = root_s[RT_W-1];
	assign out_side  = side_s[RT_W-1];

endmodule
`default_nettype wire

### design/point_segment_distance_3d.sv
`default_nettype none
// Closest point on a 3-D segment to a query point, and the distance to it.
// Input: one transaction per cycle at most. A transaction is taken at a rising
//   edge with start high and busy low; busy is always low, so an item may be
//   presented in every cycle. Fields are the segment start, segment end and
//   query point, signed Q16.16.
// Output: done is high for exactly one cycle per transaction, with distance
//   (unsigned Q17.16, truncated), near_x/y/z (closest point) and position
//   (clamped segment parameter, Q1.16, 65536 means one) valid in that cycle.
// Stages: 4 front stages, 16 divider stages, 5 middle stages and 34 square root
//   stages lie between the accepting edge and done. Throughput: one transaction
//   per cycle, set by the fully pipelined divider and square root, one bit per
//   stage each.
// Results leave in input order. The receiver cannot stall: results are not
//   held, so done must be sampled in its cycle.
// Reset (arst_n low) clears all valid flags; items in flight are dropped.
module point_segment_distance_3d (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [psd_pkg::CW-1:0]  start_x,
	input  logic signed [psd_pkg::CW-1:0]  start_y,
	input  logic signed [psd_pkg::CW-1:0]  start_z,
	input  logic signed [psd_pkg::CW-1:0]  end_x,
	input  logic signed [psd_pkg::CW-1:0]  end_y,
	input  logic signed [psd_pkg::CW-1:0]  end_z,
	input  logic signed [psd_pkg::CW-1:0]  query_x,
	input  logic signed [psd_pkg::CW-1:0]  query_y,
	input  logic signed [psd_pkg::CW-1:0]  query_z,
	output logic                           done,
	output logic [psd_pkg::DIST_W-1:0]     distance,
	output logic signed [psd_pkg::CW-1:0]  near_x,
	output logic signed [psd_pkg::CW-1:0]  near_y,
	output logic signed [psd_pkg::CW-1:0]  near_z,
	output logic [psd_pkg::POS_W-1:0]      position
);
	import psd_pkg::*;

	logic signed [CW-1:0] in_p [3];
	logic signed [CW-1:0] in_e [3];
	logic signed [CW-1:0] in_q [3];

	assign busy = 1'b0;
	assign in_p[0] = start_x;
	assign in_p[1] = start_y;
	assign in_p[2] = start_z;
	assign in_e[0] = end_x;
	assign in_e[1] = end_y;
	assign in_e[2] = end_z;
	assign in_q[0] = query_x;
	assign in_q[1] = query_y;
	assign in_q[2] = query_z;

	// ---- stage 1: segment vector v = e - p and w = q - p
	logic                 vld_s1;
	logic signed [CW-1:0] p_s1 [3];
	logic signed [CW-1:0] e_s1 [3];
	logic signed [CW-1:0] q_s1 [3];
	logic signed [VW-1:0] v_s1 [3];
	logic signed [VW-1:0] w_s1 [3];

	// ---- stage 2: products, plus |v| and its sign for the later scaling
	logic                 vld_s2;
	logic signed [CW-1:0] p_s2 [3];
	logic signed [CW-1:0] e_s2 [3];
	logic signed [CW-1:0] q_s2 [3];
	logic [VW-1:0]        vmag_s2 [3];
	logic [2:0]           vneg_s2;
	logic [PW-1:0]        lsq_s2 [3];
	logic signed [PW-1:0] dotp_s2 [3];

	// ---- stage 3: squared length and dot product
	logic                 vld_s3;
	div_side_t            side_c;
	div_side_t            side_s3;
	logic [LW-1:0]        len_s3;
	logic signed [DW-1:0] dot_s3;

	// ---- stage 4: clamp decision, divider set-up
	logic                 vld_s4;
	div_side_t            side_s4;
	logic [LW-1:0]        len_s4;
	logic [LW-1:0]        rem_s4;
	mode_t                mode_c;

	// ---- divider output
	logic                 dv_valid;
	logic [PF-1:0]        dv_quot;
	div_side_t            dv_side;
	logic [POS_W-1:0]     pos_c;

	// ---- stage 5: |v| * s
	logic                 vld_s5;
	div_side_t            side_s5;
	logic [POS_W-1:0]     pos_s5;
	logic [STP_W-1:0]     step_s5 [3];

	// ---- stage 6: closest point
	logic                 vld_s6;
	logic signed [CW-1:0] near_s6 [3];
	logic signed [CW-1:0] q_s6 [3];
	logic [POS_W-1:0]     pos_s6;

	// ---- stage 7: difference to the query point
	logic                 vld_s7;
	logic signed [CW-1:0] near_s7 [3];
	logic signed [VW-1:0] diff_s7 [3];
	logic [POS_W-1:0]     pos_s7;

	// ---- stage 8: squares
	logic                 vld_s8;
	logic signed [CW-1:0] near_s8 [3];
	logic [PW-1:0]        sq_s8 [3];
	logic [POS_W-1:0]     pos_s8;

	// ---- stage 9: squared distance
	logic                 vld_s9;
	sq_side_t             sqs_s9;
	logic [SQ_W-1:0]      dsq_s9;

	logic                 rt_valid;
	logic [RT_W-1:0]      rt_root;
	sq_side_t             rt_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= dv_valid;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// front end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			p_s1[i] <= in_p[i];
			e_s1[i] <= in_e[i];
			q_s1[i] <= in_q[i];
			v_s1[i] <= VW'(in_e[i]) - VW'(in_p[i]);
			w_s1[i] <= VW'(in_q[i]) - VW'(in_p[i]);

			p_s2[i]    <= p_s1[i];
			e_s2[i]    <= e_s1[i];
			q_s2[i]    <= q_s1[i];
			vneg_s2[i] <= v_s1[i][VW-1];
			vmag_s2[i] <= v_s1[i][VW-1] ? VW'(-v_s1[i]) : VW'(v_s1[i]);
			lsq_s2[i]  <= PW'(v_s1[i] * v_s1[i]);
			dotp_s2[i] <= PW'(w_s1[i] * v_s1[i]);
		end
		len_s3 <= LW'(lsq_s2[0]) + LW'(lsq_s2[1]) + LW'(lsq_s2[2]);
		dot_s3 <= DW'(dotp_s2[0]) + DW'(dotp_s2[1]) + DW'(dotp_s2[2]);
	end

	always_comb begin
		side_c.mode = MODE_START;
		side_c.vneg = vneg_s2;
		for (int i = 0; i < 3; i++) begin
			side_c.p[i]    = p_s2[i];
			side_c.e[i]    = e_s2[i];
			side_c.q[i]    = q_s2[i];
			side_c.vmag[i] = vmag_s2[i];
		end
	end

	// side data is captured one stage later, so it rides beside len/dot
	always_ff @(posedge clk) begin
		side_s3 <= side_c;
	end

	// clamp: at or before start (or zero length), at or past end, or strictly inside
	always_comb begin
		if (len_s3 == '0 || dot_s3[DW-1] || dot_s3 == '0) begin
			mode_c = MODE_START;
		end else if (dot_s3 >= $signed(DW'(len_s3))) begin
			mode_c = MODE_END;
		end else begin
			mode_c = MODE_INNER;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= '{p: side_s3.p, e: side_s3.e, q: side_s3.q,
			vmag: side_s3.vmag, vneg: side_s3.vneg, mode: mode_c};
		len_s4  <= len_s3;
		rem_s4  <= LW'(dot_s3);
	end

	psd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.in_len    (len_s4),
		.in_rem    (rem_s4),
		.in_side   (side_s4),
		.out_valid (dv_valid),
		.out_quot  (dv_quot),
		.out_side  (dv_side)
	);

	always_comb begin
		unique case (dv_side.mode)
			MODE_START: pos_c = '0;
			MODE_END:   pos_c = POS_ONE;
			MODE_INNER: pos_c = POS_W'(dv_quot);
			default:    pos_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		side_s5 <= dv_side;
		pos_s5  <= pos_c;
		for (int i = 0; i < 3; i++) begin
			step_s5[i] <= STP_W'(dv_side.vmag[i]) * STP_W'(pos_c);
		end
	end

	// closest point; the scaled step never exceeds |v|, so it fits VW bits
	always_ff @(posedge clk) begin
		pos_s6 <= pos_s5;
		for (int i = 0; i < 3; i++) begin
			q_s6[i] <= side_s5.q[i];
			unique case (side_s5.mode)
				MODE_START: near_s6[i] <= side_s5.p[i];
				MODE_END:   near_s6[i] <= side_s5.e[i];
				MODE_INNER: begin
					if (side_s5.vneg[i]) begin
						near_s6[i] <= CW'(VW'(side_s5.p[i]) - step_s5[i][PF +: VW]);
					end else begin
						near_s6[i] <= CW'(VW'(side_s5.p[i]) + step_s5[i][PF +: VW]);
					end
				end
				default:    near_s6[i] <= side_s5.p[i];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pos_s7 <= pos_s6;
		pos_s8 <= pos_s7;
		for (int i = 0; i < 3; i++) begin
			near_s7[i] <= near_s6[i];
			diff_s7[i] <= VW'(near_s6[i]) - VW'(q_s6[i]);
			near_s8[i] <= near_s7[i];
			sq_s8[i]   <= PW'(diff_s7[i] * diff_s7[i]);
			sqs_s9.near[i] <= near_s8[i];
		end
		sqs_s9.pos <= pos_s8;
		dsq_s9     <= SQ_W'(sq_s8[0]) + SQ_W'(sq_s8[1]) + SQ_W'(sq_s8[2]);
	end

	psd_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s9),
		.in_val    (dsq_s9),
		.in_side   (sqs_s9),
		.out_valid (rt_valid),
		.out_root  (rt_root),
		.out_side  (rt_side)
	);

	assign done     = rt_valid;
	assign distance = rt_root[DIST_W-1:0];
	assign near_x   = rt_side.near[0];
	assign near_y   = rt_side.near[1];
	assign near_z   = rt_side.near[2];
	assign position = rt_side.pos;

	// every accepted transaction brings a done, and done comes only for accepted ones
	a_lat_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result missing after accepted transaction");

	a_lat_none: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LAT !done)
		else $error("result without a transaction");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (position <= POS_ONE))
		else $error("segment parameter out of range");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown({distance, near_x, near_y, near_z, position}))
		else $error("unknown bits on a result");

endmodule
`default_nettype wire
